// ----- rtl/rti_pkg.sv -----
// Shared types and codes for the ray/triangle intersection pipeline.
`default_nettype none
package rti_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_MISS  = 2'd0,
		ST_HIT   = 2'd1,
		ST_PLANE = 2'd2,
		ST_DEGEN = 2'd3
	} status_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_START_Z = 3'd2,
		REG_END_X   = 3'd3,
		REG_END_Y   = 3'd4,
		REG_END_Z   = 3'd5,
		REG_SPARE6  = 3'd6,
		REG_SPARE7  = 3'd7
	} reg_idx_t;

	// Sign and zero flags of one exact triple product.
	typedef struct packed {
		logic neg;
		logic zero;
	} sign_flags_t;

endpackage
`default_nettype wire

// ----- rtl/rti_front.sv -----
// Front end: edge vectors, plane normal and the exact plane and edge products.
`default_nettype none
module rti_front import rti_pkg::*; #(
	parameter int W = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [W-1:0]           va [3],
	input  logic signed [W-1:0]           vb [3],
	input  logic signed [W-1:0]           vc [3],
	input  logic signed [W-1:0]           rs [3],
	input  logic signed [W-1:0]           re [3],
	output logic signed [3*W+5:0]         a_s3,
	output logic signed [3*W+5:0]         b_s3,
	output logic                          nz_s3,
	output sign_flags_t                   tri_s3 [3],
	output logic signed [W-1:0]           s_s3 [3],
	output logic signed [W:0]             d_s3 [3]
);
	localparam int DW = W + 1;
	localparam int NW = 2 * DW + 1;
	localparam int PW = 3 * W + 6;

	logic signed [DW-1:0] u_s1 [3], v_s1 [3], w0_s1 [3], d_s1 [3];
	logic signed [DW-1:0] sa_s1 [3], sb_s1 [3], sc_s1 [3];
	logic signed [W-1:0]  s_s1 [3], s_s2 [3];
	logic signed [DW-1:0] w0_s2 [3], d_s2 [3];
	logic signed [NW-1:0] n_s2 [3], c1_s2 [3], c2_s2 [3], c3_s2 [3];
	logic signed [PW-1:0] t_c [3];

	// Stage 1: difference vectors.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				u_s1[k]  <= DW'(vb[k]) - DW'(va[k]);
				v_s1[k]  <= DW'(vc[k]) - DW'(va[k]);
				w0_s1[k] <= DW'(rs[k]) - DW'(va[k]);
				sa_s1[k] <= DW'(va[k]) - DW'(rs[k]);
				sb_s1[k] <= DW'(vb[k]) - DW'(rs[k]);
				sc_s1[k] <= DW'(vc[k]) - DW'(rs[k]);
				d_s1[k]  <= DW'(re[k]) - DW'(rs[k]);
				s_s1[k]  <= rs[k];
			end
		end
	end

	// Stage 2: plane normal and the edge cross products c1, c2 and c3.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				n_s2[k]  <= v_s1[(k+1)%3] * u_s1[(k+2)%3] - v_s1[(k+2)%3] * u_s1[(k+1)%3];
				c1_s2[k] <= sb_s1[(k+1)%3] * sc_s1[(k+2)%3]
					- sb_s1[(k+2)%3] * sc_s1[(k+1)%3];
				c2_s2[k] <= sc_s1[(k+1)%3] * sa_s1[(k+2)%3]
					- sc_s1[(k+2)%3] * sa_s1[(k+1)%3];
				c3_s2[k] <= sa_s1[(k+1)%3] * sb_s1[(k+2)%3]
					- sa_s1[(k+2)%3] * sb_s1[(k+1)%3];
				w0_s2[k] <= w0_s1[k];
				d_s2[k]  <= d_s1[k];
				s_s2[k]  <= s_s1[k];
			end
		end
	end

	// Edge triple products against the ray direction.
	always_comb begin
		t_c[0] = c1_s2[0] * d_s2[0] + c1_s2[1] * d_s2[1] + c1_s2[2] * d_s2[2];
		t_c[1] = c2_s2[0] * d_s2[0] + c2_s2[1] * d_s2[1] + c2_s2[2] * d_s2[2];
		t_c[2] = c3_s2[0] * d_s2[0] + c3_s2[1] * d_s2[1] + c3_s2[2] * d_s2[2];
	end

	// Stage 3: plane distance terms and edge sign flags.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3  <= -(n_s2[0] * w0_s2[0] + n_s2[1] * w0_s2[1] + n_s2[2] * w0_s2[2]);
			b_s3  <= n_s2[0] * d_s2[0] + n_s2[1] * d_s2[1] + n_s2[2] * d_s2[2];
			nz_s3 <= (n_s2[0] == '0) && (n_s2[1] == '0) && (n_s2[2] == '0);
			for (int k = 0; k < 3; k++) begin
				tri_s3[k].neg  <= t_c[k][PW-1];
				tri_s3[k].zero <= (t_c[k] == '0);
				s_s3[k] <= s_s2[k];
				d_s3[k] <= d_s2[k];
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rti_place.sv -----
// One coordinate of the hit point: exact quotient, rounding and saturation.
`default_nettype none
module rti_place #(
	parameter int W = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic                  keep,
	input  logic signed [W-1:0]   s,
	input  logic signed [W:0]     d,
	input  logic signed [3*W+5:0] a,
	input  logic signed [3*W+5:0] b,
	output logic signed [W-1:0]   hit
);
	localparam int PW = 3 * W + 6;
	localparam int QW = 4 * W + 8;
	localparam int RW = QW + 1;

	logic signed [QW-1:0] sb_p1, ad_p1, num_c;
	logic [PW-1:0]        absb_p1, absb_p2;
	logic [QW-1:0]        absnum_p2;
	logic                 bneg_p1, keep_p1, keep_p2, neg_p2;
	logic [RW-1:0]        nn_c;

	logic [RW-1:0] r_s   [W+1];
	logic [PW:0]   dd_s  [W+1];
	logic [W-1:0]  q_s   [W+1];
	logic          neg_s [W+1];
	logic          big_s [W+1];
	logic          keep_s [W+1];

	// Products of the numerator and magnitude of the denominator.
	always_ff @(posedge clk) begin
		if (en) begin
			sb_p1   <= s * b;
			ad_p1   <= a * d;
			bneg_p1 <= b[PW-1];
			absb_p1 <= b[PW-1] ? PW'(-b) : PW'(b);
			keep_p1 <= keep;
		end
	end

	// Signed numerator folded into magnitude and result sign.
	assign num_c = sb_p1 + ad_p1;

	always_ff @(posedge clk) begin
		if (en) begin
			absnum_p2 <= num_c[QW-1] ? QW'(-num_c) : QW'(num_c);
			neg_p2    <= num_c[QW-1] ^ bneg_p1;
			absb_p2   <= absb_p1;
			keep_p2   <= keep_p1;
		end
	end

	// Rounding offset: quotient of (2|num| + |b|) by 2|b|.
	assign nn_c = {absnum_p2, 1'b0} + RW'(absb_p2);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]    <= nn_c;
			dd_s[0]   <= {absb_p2, 1'b0};
			q_s[0]    <= '0;
			neg_s[0]  <= neg_p2;
			big_s[0]  <= nn_c >= (RW'({absb_p2, 1'b0}) << W);
			keep_s[0] <= keep_p2;
		end
	end

	// Restoring division, one quotient bit per stage, most significant first.
	for (genvar j = 1; j <= W; j++) begin : g_div
		logic [RW-1:0] trial;
		assign trial = RW'(dd_s[j-1]) << (W - j);
		always_ff @(posedge clk) begin
			if (en) begin
				if (r_s[j-1] >= trial) begin
					r_s[j] <= r_s[j-1] - trial;
					q_s[j] <= {q_s[j-1][W-2:0], 1'b1};
				end else begin
					r_s[j] <= r_s[j-1];
					q_s[j] <= {q_s[j-1][W-2:0], 1'b0};
				end
				dd_s[j]   <= dd_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				big_s[j]  <= big_s[j-1];
				keep_s[j] <= keep_s[j-1];
			end
		end
	end

	// Saturation to the coordinate range; zero when no hit.
	always_ff @(posedge clk) begin
		if (en) begin
			if (!keep_s[W]) begin
				hit <= '0;
			end else if (neg_s[W]) begin
				if (big_s[W] || (q_s[W][W-1] && (q_s[W][W-2:0] != '0)))
					hit <= {1'b1, {(W-1){1'b0}}};
				else
					hit <= -$signed(q_s[W]);
			end else begin
				if (big_s[W] || q_s[W][W-1])
					hit <= {1'b0, {(W-1){1'b1}}};
				else
					hit <= $signed(q_s[W]);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ray_triangle_intersect.sv -----
// Throughput: one triangle per cycle while m_tready keeps up; the hit-point divider
// is a pipeline with one quotient bit per stage, so it never holds up the stream.
// Reset clears the ray registers to zero and empties the pipeline; the whole
// pipeline stalls together while a finished result waits on m_tready.
`default_nettype none
module ray_triangle_intersect import rti_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// hit_status, hit_x, hit_y, hit_z from the lowest bit up
	output logic [((3*COORD_WIDTH+9)/8)*8-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);
	localparam int W  = COORD_WIDTH;
	localparam int PW = 3 * W + 6;
	localparam int OW = ((3 * W + 9) / 8) * 8;
	localparam int PL = W + 4;
	localparam int L  = 3 + PL;

	logic signed [W-1:0]  va [3], vb [3], vc [3];
	logic signed [W-1:0]  start_q [3], end_q [3];
	logic signed [PW-1:0] a_s3, b_s3;
	logic                 nz_s3;
	sign_flags_t          tri_s3 [3];
	logic signed [W-1:0]  s_s3 [3];
	logic signed [W:0]    d_s3 [3];
	logic signed [W-1:0]  hit [3];
	logic [L-1:0]         vld_q;
	status_t              st_c;
	status_t              st_s [PL];
	logic                 en, sneg;

	// Whole pipeline advances unless the output holds an untaken result.
	assign en       = !vld_q[L-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[L-1];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			va[k] = s_tdata[k*W +: W];
			vb[k] = s_tdata[(3+k)*W +: W];
			vc[k] = s_tdata[(6+k)*W +: W];
		end
	end

	// Ray registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				start_q[k] <= '0;
				end_q[k]   <= '0;
			end
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_START_X: start_q[0] <= cfg_data;
				REG_START_Y: start_q[1] <= cfg_data;
				REG_START_Z: start_q[2] <= cfg_data;
				REG_END_X:   end_q[0]   <= cfg_data;
				REG_END_Y:   end_q[1]   <= cfg_data;
				REG_END_Z:   end_q[2]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], s_tvalid};
		end
	end

	rti_front #(.W(W)) u_front (
		.clk    (clk),
		.en     (en),
		.va     (va),
		.vb     (vb),
		.vc     (vc),
		.rs     (start_q),
		.re     (end_q),
		.a_s3   (a_s3),
		.b_s3   (b_s3),
		.nz_s3  (nz_s3),
		.tri_s3 (tri_s3),
		.s_s3   (s_s3),
		.d_s3   (d_s3)
	);

	// Classification: degenerate, parallel, behind the ray, or edge tests.
	assign sneg = !b_s3[PW-1];

	always_comb begin
		priority if (nz_s3) begin
			st_c = ST_DEGEN;
		end else if (b_s3 == '0) begin
			st_c = (a_s3 == '0) ? ST_PLANE : ST_MISS;
		end else if ((a_s3 != '0) && (a_s3[PW-1] != b_s3[PW-1])) begin
			st_c = ST_MISS;
		end else if ((tri_s3[0].zero || tri_s3[0].neg == sneg) &&
				(tri_s3[1].zero || tri_s3[1].neg == sneg) &&
				(tri_s3[2].zero || tri_s3[2].neg == sneg)) begin
			st_c = ST_HIT;
		end else begin
			st_c = ST_MISS;
		end
	end

	// Status waits alongside the hit-point pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= st_c;
			for (int i = 1; i < PL; i++) st_s[i] <= st_s[i-1];
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_place
		rti_place #(.W(W)) u_place (
			.clk  (clk),
			.en   (en),
			.keep (st_c == ST_HIT),
			.s    (s_s3[k]),
			.d    (d_s3[k]),
			.a    (a_s3),
			.b    (b_s3),
			.hit  (hit[k])
		);
	end

	assign m_tdata = OW'({hit[2], hit[1], hit[0], st_s[PL-1]});

endmodule
`default_nettype wire
